[rtl/core/hill_cipher_3x3_mod37_encrypt_core_macros.svh]
// Assertion macros for the 3x3 mod-37 Hill cipher encrypt core.
`ifndef HILL_CIPHER_3X3_MOD37_ENCRYPT_CORE_MACROS_SVH
`define HILL_CIPHER_3X3_MOD37_ENCRYPT_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication under reset.
`define HC_ASSERT_IMPL(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("assertion failed: lbl");
// Next-cycle implication under reset.
`define HC_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed: lbl");
`else
`define HC_ASSERT_IMPL(lbl, clk, rstn, pre, post)
`define HC_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif
`endif

[rtl/core/hc37_pkg.sv]
// Constants, types and helper functions for the 3x3 mod-37 Hill cipher core.
package hc37_pkg;

  localparam int SymbolCount = 37;
  localparam int SymWidth    = 6;
  localparam int CharWidth   = 8;
  localparam int KeyWidth    = 3 * SymWidth;
  localparam int SumWidth    = 13;
  localparam int RecipShift  = 16;
  localparam int RecipMul    = (1 << RecipShift) / SymbolCount;

  localparam logic [SymWidth-1:0]  SymDot       = 6'd36;
  localparam logic [SymWidth-1:0]  SymLastDigit = 6'd9;
  localparam logic [CharWidth-1:0] CharDot      = 8'h2E;
  localparam logic [CharWidth-1:0] CharZero     = 8'h30;
  localparam logic [CharWidth-1:0] CharNine     = 8'h39;
  localparam logic [CharWidth-1:0] CharUpperA   = 8'h41;
  localparam logic [CharWidth-1:0] CharUpperZ   = 8'h5A;
  localparam logic [CharWidth-1:0] LetterOffset = 8'd55;

  // Register indexes on the configuration port.
  localparam logic [1:0] CfgKeyRowZero = 2'd0;
  localparam logic [1:0] CfgKeyRowOne  = 2'd1;
  localparam logic [1:0] CfgKeyRowTwo  = 2'd2;

  typedef logic [SymWidth-1:0] sym_t;
  typedef logic [SumWidth-1:0] sum_t;

  typedef struct packed {
    logic bad;
    sym_t sym;
  } sym_map_t;

  function automatic sym_map_t char_to_sym(input logic [CharWidth-1:0] c);
    sym_map_t m;
    m.bad = 1'b0;
    m.sym = '0;
    if (c == CharDot) begin
      m.sym = SymDot;
    end else if (c >= CharZero && c <= CharNine) begin
      m.sym = SymWidth'(c - CharZero);
    end else if (c >= CharUpperA && c <= CharUpperZ) begin
      m.sym = SymWidth'(c - LetterOffset);
    end else begin
      m.bad = 1'b1;
    end
    return m;
  endfunction

  function automatic logic [CharWidth-1:0] sym_to_char(input sym_t s);
    logic [CharWidth-1:0] c;
    if (s == SymDot) begin
      c = CharDot;
    end else if (s <= SymLastDigit) begin
      c = CharWidth'(s) + CharZero;
    end else begin
      c = CharWidth'(s) + LetterOffset;
    end
    return c;
  endfunction

  // Reciprocal multiply gives the quotient or one less; one subtract corrects it.
  function automatic sym_t mod37(input sum_t x);
    logic [SumWidth+RecipShift-5:0] prod;
    logic [7:0]                     q;
    logic [SumWidth:0]              qm;
    logic [6:0]                     r;
    prod = (SumWidth+RecipShift-4)'(x) * (SumWidth+RecipShift-4)'(RecipMul);
    // Quotient of the largest row sum stays below 256.
    q    = prod[RecipShift+7:RecipShift];
    qm   = (SumWidth+1)'(q) * (SumWidth+1)'(SymbolCount);
    r    = 7'((SumWidth+1)'(x) - qm);
    if (r >= 7'(SymbolCount)) begin
      r = r - 7'(SymbolCount);
    end
    return r[SymWidth-1:0];
  endfunction

endpackage

[rtl/core/hill_cipher_3x3_mod37_encrypt_core.sv]
// Top level of the 3x3 mod-37 Hill cipher encryptor: block collect, matrix multiply, emit.
// Flow: a block-closing request is taken into the vector register, the row sums then into the
// sum register and the characters into the result register, each stage held by a stall below.
// Throughput: one request per cycle for full blocks and one char out per cycle, both while
// m_axis_tready stays high; early closes wait. Characters leave the result register in order.
// Reset (rst_ni low, asynchronous): empties the open block and all pipeline stages, keys to 0.
`include "hill_cipher_3x3_mod37_encrypt_core_macros.svh"
module hill_cipher_3x3_mod37_encrypt_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_idx_i,
  input  logic [hc37_pkg::KeyWidth-1:0]   cfg_data_i,
  // plaintext requests
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // [7:0] in_char
  input  logic                            s_axis_tlast,   // in_last
  // ciphertext results
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,   // [7:0] out_char
  output logic                            m_axis_tlast,   // run_last
  output logic [1:0]                      m_axis_tuser    // [0] message_end, [1] bad_char
);
  import hc37_pkg::*;

  // Key matrix, one 18-bit row per register, column 0 in the low bits.
  logic [2:0][KeyWidth-1:0] key_q;

  // Open block.
  sym_t [1:0] buf_q;
  logic [1:0] fill_q;
  logic       blk_bad_q;

  // Stage 1: closed block vector.
  logic       vec_valid_q;
  sym_t [2:0] vec_q, vec_d;
  logic       vec_last_q, vec_bad_q;

  // Stage 2: row sums.
  logic       sum_valid_q;
  sum_t [2:0] sum_q, sum_d;
  logic       sum_last_q, sum_bad_q;

  // Stage 3: ciphertext characters and serializer.
  logic                        res_valid_q;
  logic [2:0][CharWidth-1:0]   res_char_q, res_char_d;
  logic                        res_last_q, res_bad_q;
  logic [1:0]                  res_idx_q;

  logic     in_acc, out_acc, closes;
  logic     out_free, sum_adv, sum_free, vec_adv, vec_free;
  sym_map_t in_map;

  // Pipeline flow: each stage moves on when the one after it is empty or draining.
  assign out_acc  = m_axis_tvalid && m_axis_tready;
  assign out_free = !res_valid_q || (m_axis_tready && res_idx_q == 2'd2);
  assign sum_adv  = sum_valid_q && out_free;
  assign sum_free = !sum_valid_q || sum_adv;
  assign vec_adv  = vec_valid_q && sum_free;
  assign vec_free = !vec_valid_q || vec_adv;

  assign s_axis_tready = vec_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign in_map = char_to_sym(s_axis_tdata);
  // A third symbol or the message end closes the block.
  assign closes = fill_q[1] || s_axis_tlast;

  // Place held symbols first, this symbol next, zeros for the missing places.
  always_comb begin
    vec_d = '0;
    if (fill_q[1]) begin
      vec_d[0] = buf_q[0];
      vec_d[1] = buf_q[1];
      vec_d[2] = in_map.sym;
    end else if (fill_q[0]) begin
      vec_d[0] = buf_q[0];
      vec_d[1] = in_map.sym;
    end else begin
      vec_d[0] = in_map.sym;
    end
  end

  // Row i of the key times the block vector; products are independent.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_d[i] = '0;
      for (int k = 0; k < 3; k++) begin
        sum_d[i] = sum_d[i] + SumWidth'(key_q[i][SymWidth*k +: SymWidth]) * SumWidth'(vec_q[k]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res_char_d[i] = sym_to_char(mod37(sum_q[i]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q       <= '0;
      buf_q       <= '0;
      fill_q      <= '0;
      blk_bad_q   <= 1'b0;
      vec_valid_q <= 1'b0;
      sum_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
      res_idx_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgKeyRowZero: key_q[0] <= cfg_data_i;
          CfgKeyRowOne:  key_q[1] <= cfg_data_i;
          CfgKeyRowTwo:  key_q[2] <= cfg_data_i;
          default: ;
        endcase
      end

      // Collect symbols or hand the closed block to stage 1 and clear.
      if (in_acc) begin
        if (closes) begin
          buf_q     <= '0;
          fill_q    <= '0;
          blk_bad_q <= 1'b0;
        end else begin
          buf_q[fill_q[0]] <= in_map.sym;
          fill_q           <= fill_q + 2'd1;
          blk_bad_q        <= blk_bad_q | in_map.bad;
        end
      end

      if (in_acc && closes) begin
        vec_valid_q <= 1'b1;
      end else if (vec_adv) begin
        vec_valid_q <= 1'b0;
      end

      if (vec_adv) begin
        sum_valid_q <= 1'b1;
      end else if (sum_adv) begin
        sum_valid_q <= 1'b0;
      end

      // Step through the three characters; reload when the last one leaves.
      if (sum_adv) begin
        res_valid_q <= 1'b1;
        res_idx_q   <= '0;
      end else if (out_acc) begin
        if (res_idx_q == 2'd2) begin
          res_valid_q <= 1'b0;
          res_idx_q   <= '0;
        end else begin
          res_idx_q <= res_idx_q + 2'd1;
        end
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_acc && closes) begin
      vec_q      <= vec_d;
      vec_last_q <= s_axis_tlast;
      vec_bad_q  <= blk_bad_q | in_map.bad;
    end
    if (vec_adv) begin
      sum_q      <= sum_d;
      sum_last_q <= vec_last_q;
      sum_bad_q  <= vec_bad_q;
    end
    if (sum_adv) begin
      res_char_q <= res_char_d;
      res_last_q <= sum_last_q;
      res_bad_q  <= sum_bad_q;
    end
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = res_char_q[res_idx_q];
  assign m_axis_tlast  = (res_idx_q == 2'd2);
  assign m_axis_tuser  = {res_bad_q, res_last_q};

  `HC_ASSERT_IMPL(a_fill_range, clk_i, rst_ni, 1'b1, fill_q != 2'd3)
  `HC_ASSERT_IMPL(a_idle_idx, clk_i, rst_ni, !res_valid_q, res_idx_q == 2'd0)
  `HC_ASSERT_NEXT(a_close_loads, clk_i, rst_ni, in_acc && closes, vec_valid_q && fill_q == 2'd0)
  `HC_ASSERT_NEXT(a_sum_holds, clk_i, rst_ni, sum_valid_q && !out_free, sum_valid_q && $stable(sum_q))

endmodule

[dv/hill_cipher_3x3_mod37_encrypt_checker.sv]
// Checker for the Hill cipher core: mirrors keys and open block, predicts ciphertext, compares.
module hill_cipher_3x3_mod37_encrypt_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [hc37_pkg::KeyWidth-1:0] cfg_data_i,
  input  logic                          plain_valid_i,
  input  logic                          plain_ready_i,
  input  logic [7:0]                    plain_char_i,
  input  logic                          plain_last_i,
  input  logic                          cipher_valid_i,
  input  logic                          cipher_ready_i,
  input  logic [7:0]                    cipher_char_i,
  input  logic                          cipher_last_i,
  input  logic [1:0]                    cipher_user_i,  // [0] message_end, [1] bad_char
  output int                            mismatch_count_o,
  output int                            pending_o
);
  import hc37_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       run_last;
    logic       msg_end;
    logic       bad;
  } cipher_char_t;

  logic [KeyWidth-1:0] key_row [3];
  logic [5:0]          held_sym [2];
  logic [1:0]          held_count;
  logic                held_bad;
  cipher_char_t        cipher_q [$];
  int                  mismatches = 0;

  assign mismatch_count_o = mismatches;
  assign pending_o        = cipher_q.size();

  // {bad, symbol}; anything outside the alphabet reads as symbol zero
  function automatic logic [6:0] symbol_of(input logic [7:0] c);
    if (c == ".") return {1'b0, 6'd36};
    if (c >= "0" && c <= "9") return {1'b0, 6'(c - "0")};
    if (c >= "A" && c <= "Z") return {1'b0, 6'(c - "A" + 8'd10)};
    return {1'b1, 6'd0};
  endfunction

  function automatic logic [7:0] char_of(input logic [5:0] s);
    if (s == 6'd36) return ".";
    if (s <= 6'd9) return 8'(s) + "0";
    return 8'(s) - 8'd10 + "A";
  endfunction

  task automatic take_plain(input logic [7:0] c, input logic last);
    logic [6:0]   m;
    logic [5:0]   vec [3];
    int unsigned  acc;
    cipher_char_t r;
    m = symbol_of(c);
    if (m[6]) held_bad = 1'b1;
    if (held_count < 2'd2 && !last) begin
      held_sym[held_count[0]] = m[5:0];
      held_count = held_count + 2'd1;
    end else begin
      // pad missing positions with symbol zero
      vec[0] = '0;
      vec[1] = '0;
      vec[2] = '0;
      case (held_count)
        2'd0:    vec[0] = m[5:0];
        2'd1: begin
          vec[0] = held_sym[0];
          vec[1] = m[5:0];
        end
        default: begin
          vec[0] = held_sym[0];
          vec[1] = held_sym[1];
          vec[2] = m[5:0];
        end
      endcase
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int k = 0; k < 3; k++)
          acc += int'(key_row[i][6*k +: 6]) * int'(vec[k]);
        acc = acc % SymbolCount;
        r.ch       = char_of(6'(acc));
        r.run_last = (i == 2);
        r.msg_end  = last;
        r.bad      = held_bad;
        cipher_q.push_back(r);
      end
      held_sym[0] = '0;
      held_sym[1] = '0;
      held_count  = '0;
      held_bad    = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cipher_char_t want;
    if (!rst_ni) begin
      key_row[0]  = '0;
      key_row[1]  = '0;
      key_row[2]  = '0;
      held_sym[0] = '0;
      held_sym[1] = '0;
      held_count  = '0;
      held_bad    = 1'b0;
      cipher_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgKeyRowZero: key_row[0] = cfg_data_i;
          CfgKeyRowOne:  key_row[1] = cfg_data_i;
          CfgKeyRowTwo:  key_row[2] = cfg_data_i;
          default: ;
        endcase
      end
      if (plain_valid_i && plain_ready_i) take_plain(plain_char_i, plain_last_i);
      if (cipher_valid_i && cipher_ready_i) begin
        if (cipher_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected ciphertext char: expected none, got %h", $time,
                   cipher_char_i);
        end else begin
          want = cipher_q.pop_front();
          if (cipher_char_i !== want.ch) begin
            mismatches++;
            $display("%0t: out_char expected %h, got %h", $time, want.ch, cipher_char_i);
          end
          if (cipher_last_i !== want.run_last) begin
            mismatches++;
            $display("%0t: run_last expected %b, got %b", $time, want.run_last,
                     cipher_last_i);
          end
          if (cipher_user_i[0] !== want.msg_end) begin
            mismatches++;
            $display("%0t: message_end expected %b, got %b", $time, want.msg_end,
                     cipher_user_i[0]);
          end
          if (cipher_user_i[1] !== want.bad) begin
            mismatches++;
            $display("%0t: bad_char expected %b, got %b", $time, want.bad,
                     cipher_user_i[1]);
          end
        end
      end
    end
  end

endmodule

[dv/hill_cipher_3x3_mod37_encrypt_core_test.sv]
// Testbench top for the Hill cipher core: clock, reset, keys, plaintext stimulus and verdict.
module hill_cipher_3x3_mod37_encrypt_core_test;
  import hc37_pkg::*;

  localparam int CycleLimit     = 300000;
  localparam int DrainCycles    = 8;   // settle time after the last expected char drains
  localparam int PhaseCount     = 8;
  localparam int CharsPerPhase  = 50;
  localparam int DirectedCount  = 21;
  localparam logic [KeyWidth-1:0] KeyRowAllOnes = '1;

  typedef enum logic [1:0] {
    IdleNone,
    IdleSender,
    IdleReceiver,
    IdleBoth
  } idle_mode_e;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [1:0]          cfg_idx_i     = CfgKeyRowZero;
  logic [KeyWidth-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;
  logic                s_axis_tlast  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;
  logic                m_axis_tlast;
  logic [1:0]          m_axis_tuser;

  idle_mode_e idle_mode = IdleNone;
  int         mismatch_count;
  int         cipher_pending;
  int         cycle_count = 0;

  hill_cipher_3x3_mod37_encrypt_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  hill_cipher_3x3_mod37_encrypt_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .plain_valid_i    (s_axis_tvalid),
    .plain_ready_i    (s_axis_tready),
    .plain_char_i     (s_axis_tdata),
    .plain_last_i     (s_axis_tlast),
    .cipher_valid_i   (m_axis_tvalid),
    .cipher_ready_i   (m_axis_tready),
    .cipher_char_i    (m_axis_tdata),
    .cipher_last_i    (m_axis_tlast),
    .cipher_user_i    (m_axis_tuser),
    .mismatch_count_o (mismatch_count),
    .pending_o        (cipher_pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Stop a hung run; the limit is many times the slowest legal run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("hill_cipher_3x3_mod37_encrypt_core: mismatch");
      $finish;
    end
  end

  // Stall the ciphertext side according to the current phase.
  always @(posedge clk_i) begin
    case (idle_mode)
      IdleReceiver: m_axis_tready <= ($urandom_range(99) >= 80);
      IdleBoth:     m_axis_tready <= ($urandom_range(99) >= 21);
      default:      m_axis_tready <= 1'b1;
    endcase
  end

  function automatic bit sender_idles();
    case (idle_mode)
      IdleSender: return $urandom_range(99) < 80;
      IdleBoth:   return $urandom_range(99) < 21;
      default:    return 1'b0;
    endcase
  endfunction

  // Pack three key symbols, column 0 in the low bits.
  function automatic logic [KeyWidth-1:0] key_row(input logic [5:0] c0, input logic [5:0] c1,
                                                  input logic [5:0] c2);
    return {c2, c1, c0};
  endfunction

  // Random row: mostly legal symbols, sometimes raw bits (symbols above 36).
  function automatic logic [KeyWidth-1:0] random_row();
    if ($urandom_range(3) == 0) return KeyWidth'($urandom_range(0, (1 << KeyWidth) - 1));
    return key_row(6'($urandom_range(36)), 6'($urandom_range(36)), 6'($urandom_range(36)));
  endfunction

  // Write all three key rows back to back; the block is idle here.
  task automatic load_keys(input logic [KeyWidth-1:0] r0, input logic [KeyWidth-1:0] r1,
                           input logic [KeyWidth-1:0] r2);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgKeyRowZero;
    cfg_data_i <= r0;
    @(posedge clk_i);
    cfg_idx_i  <= CfgKeyRowOne;
    cfg_data_i <= r1;
    @(posedge clk_i);
    cfg_idx_i  <= CfgKeyRowTwo;
    cfg_data_i <= r2;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Offer one plaintext request and hold it until the core takes it.
  task automatic send_char(input logic [7:0] c, input logic last);
    while (sender_idles()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drain every expected ciphertext char, then let the pipeline settle.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    // Let the checker count the request taken at this edge.
    @(posedge clk_i);
    while (cipher_pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Directed plaintext: alphabet edges, characters just outside each range, all-zero and
  // all-one bytes, blocks closed early after one and two characters, and a closing third char.
  logic [7:0] directed_char [DirectedCount] = '{
    "0", "9", "A",
    "Z", ".", "/",
    ":", "@", "[",
    "a", 8'h00, 8'hFF,
    "-",
    "B", "Y",
    "M", "N", "O",
    ".",
    8'h80, "5"
  };
  logic directed_last [DirectedCount] = '{
    0, 0, 0,
    0, 0, 0,
    0, 0, 0,
    0, 0, 0,
    1,
    0, 1,
    0, 0, 1,
    1,
    0, 1
  };

  initial begin
    int         sent;
    int         len;
    bit         noisy;
    int         sym;
    logic [7:0] c;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    load_keys(key_row(6'd1, 6'd2, 6'd3), key_row(6'd0, 6'd1, 6'd4),
              key_row(6'd5, 6'd6, 6'd0));
    for (int i = 0; i < DirectedCount; i++) send_char(directed_char[i], directed_last[i]);

    for (int phase = 0; phase < PhaseCount; phase++) begin
      wait_idle();
      // Start with the key extremes, then random keys.
      case (phase)
        0:       load_keys('0, '0, '0);
        1:       load_keys(KeyRowAllOnes, KeyRowAllOnes, KeyRowAllOnes);
        2:       load_keys(key_row(6'd36, 6'd36, 6'd36), key_row(6'd36, 6'd36, 6'd36),
                           key_row(6'd36, 6'd36, 6'd36));
        default: load_keys(random_row(), random_row(), random_row());
      endcase
      idle_mode = idle_mode_e'(phase % 4);

      sent = 0;
      while (sent < CharsPerPhase) begin
        // Most messages are clean text ending in tlast; some are noise, some never end.
        len   = $urandom_range(1, 12);
        noisy = ($urandom_range(7) == 0);
        for (int i = 0; i < len; i++) begin
          if (noisy || $urandom_range(11) == 0) begin
            c = 8'($urandom_range(255));
          end else begin
            sym = $urandom_range(36);
            if (sym == 36) c = ".";
            else if (sym < 10) c = 8'(sym) + "0";
            else c = 8'(sym - 10) + "A";
          end
          send_char(c, (i == len - 1) && !(noisy && $urandom_range(1) == 0));
          sent++;
        end
      end
      // Close any open block before the keys change.
      send_char(".", 1'b1);
    end

    wait_idle();
    if (mismatch_count == 0 && cipher_pending == 0) begin
      $display("hill_cipher_3x3_mod37_encrypt_core: match");
    end else begin
      $display("hill_cipher_3x3_mod37_encrypt_core: mismatch");
    end
    $finish;
  end

endmodule
